// ===== rtl/core/mwmt_pkg.sv =====
package mwmt_pkg;

   localparam int GRID_SIDE_DEFAULT = 9;
   localparam int START_POS_DEFAULT = 4;
   localparam int COORD_W = 4;
   localparam int SIDE_W = 5;

   localparam logic [1:0] DIR_NORTH = 2'd0;
   localparam logic [1:0] DIR_EAST = 2'd1;
   localparam logic [1:0] DIR_SOUTH = 2'd2;
   localparam logic [1:0] DIR_WEST = 2'd3;
   localparam logic [1:0] LAST_SIDE = DIR_WEST;

   typedef enum logic [1:0] {
      CMD_RESET  = 2'd0,
      CMD_RECORD = 2'd1,
      CMD_MOVE   = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic               wall_front;
      logic               wall_left;
      logic               wall_right;
      logic               wall_rear;
      logic [1:0]         direction;
      logic [COORD_W-1:0] query_x;
      logic [COORD_W-1:0] query_y;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [1:0]         heading_now;
      logic [1:0]         turns_needed;
      logic               open_unvisited;
      logic               cell_visited;
      logic [3:0]         cell_known_mask;
      logic [3:0]         cell_wall_mask;
      logic [2:0]         cell_wall_count;
   } rsp_type;

   typedef struct packed {
      logic       visited;
      logic [3:0] known;
      logic [3:0] wall;
   } cell_type;

   localparam int CELL_W = $bits(cell_type);

   typedef struct packed {
      logic               in_map;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } nb_type;

   typedef struct packed {
      logic       latch;
      logic       exec;
      logic       nb_rd;
      logic       nb_wr;
      logic       qcur;
      logic       qnb;
      logic       cell_rd;
      logic       resp;
      logic [1:0] side;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type command;
      logic    nb_in_map;
   } dp_status_type;

   function automatic nb_type neighbor(input logic [COORD_W-1:0] c,
                                       input logic [COORD_W-1:0] r,
                                       input logic [1:0] d,
                                       input logic [SIDE_W-1:0] side);
      nb_type n;
      n.col = c;
      n.row = r;
      n.in_map = 1'b0;
      unique case (d)
         DIR_NORTH: begin
            n.in_map = ({1'b0, r} + 5'd1) < side;
            n.row = r + 4'd1;
         end
         DIR_EAST: begin
            n.in_map = ({1'b0, c} + 5'd1) < side;
            n.col = c + 4'd1;
         end
         DIR_SOUTH: begin
            n.in_map = r != 4'd0;
            n.row = r - 4'd1;
         end
         default: begin
            n.in_map = c != 4'd0;
            n.col = c - 4'd1;
         end
      endcase
      return n;
   endfunction

endpackage

// ===== rtl/core/mwmt_ram.sv =====
module mwmt_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 81,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mwmt_ctrl.sv =====
module mwmt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  mwmt_pkg::dp_status_type status,
   output mwmt_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_EXEC    = 8'b0000_0010,
      S_NB_RD   = 8'b0000_0100,
      S_NB_WR   = 8'b0000_1000,
      S_QCUR    = 8'b0001_0000,
      S_QNB     = 8'b0010_0000,
      S_CELL_RD = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] side_ff, side_in;

   always_comb begin
      state_in = state_ff;
      side_in = side_ff;
      cmd = '0;
      cmd.side = side_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            unique case (status.command)
               mwmt_pkg::CMD_RECORD: begin
                  side_in = '0;
                  state_in = S_NB_RD;
               end
               mwmt_pkg::CMD_QUERY: state_in = S_QCUR;
               default: state_in = S_CELL_RD;
            endcase
         end
         S_NB_RD: begin
            if (status.nb_in_map) begin
               cmd.nb_rd = 1'b1;
               state_in = S_NB_WR;
            end else if (side_ff == mwmt_pkg::LAST_SIDE) begin
               state_in = S_CELL_RD;
            end else begin
               side_in = side_ff + 2'd1;
            end
         end
         S_NB_WR: begin
            cmd.nb_wr = 1'b1;
            if (side_ff == mwmt_pkg::LAST_SIDE) begin
               state_in = S_CELL_RD;
            end else begin
               side_in = side_ff + 2'd1;
               state_in = S_NB_RD;
            end
         end
         S_QCUR: begin
            cmd.qcur = 1'b1;
            state_in = S_QNB;
         end
         S_QNB: begin
            cmd.qnb = 1'b1;
            state_in = S_RESP;
         end
         S_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.resp = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         side_ff <= '0;
      end else begin
         state_ff <= state_in;
         side_ff <= side_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == S_EXEC)
      else $error("accepted transaction did not reach execution");

   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP |=> state_ff == S_IDLE)
      else $error("response state did not return to idle");

   a_nb_wr_after_rd: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_NB_WR |-> $past(state_ff) == S_NB_RD)
      else $error("neighbour write without a preceding read");

endmodule

// ===== rtl/core/mwmt_datapath.sv =====
module mwmt_datapath #(
   parameter int GRID_SIDE = mwmt_pkg::GRID_SIDE_DEFAULT,
   parameter int START_POS = mwmt_pkg::START_POS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mwmt_pkg::req_type      req_item,
   input  mwmt_pkg::ctrl_cmd_type cmd,
   output mwmt_pkg::dp_status_type status,
   output logic                   rsp_strobe,
   output mwmt_pkg::rsp_type      rsp_item
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AW = $clog2(CELLS);
   localparam int HOME_POS = (START_POS < GRID_SIDE) ? START_POS : GRID_SIDE - 1;
   localparam logic [mwmt_pkg::SIDE_W-1:0] SIDE = mwmt_pkg::SIDE_W'(GRID_SIDE);
   localparam logic [mwmt_pkg::COORD_W-1:0] HOME = mwmt_pkg::COORD_W'(HOME_POS);

   mwmt_pkg::req_type             req_ff;
   logic [mwmt_pkg::COORD_W-1:0]  col_ff, row_ff;
   logic [1:0]                    heading_ff, turns_ff;
   logic [CELLS-1:0]              valid_ff;
   logic                          rd_valid_ff, cond_ff, open_ff;
   logic                          rsp_strobe_ff;
   mwmt_pkg::rsp_type             rsp_ff;

   mwmt_pkg::nb_type  nb_side, nb_dir;
   mwmt_pkg::cell_type cell_rd, cur_wr, nb_wr_data, wr_data;
   logic [mwmt_pkg::CELL_W-1:0] ram_rd;
   logic [AW-1:0]     cur_addr, side_addr, dir_addr, query_addr, rd_addr, wr_addr;
   logic              rd_en, wr_en, query_in_map;
   logic [3:0]        abs_wall;
   logic [1:0]        h_right, h_rear, h_left, opp_side;

   function automatic logic [AW-1:0] cell_addr(input logic [mwmt_pkg::COORD_W-1:0] c,
                                               input logic [mwmt_pkg::COORD_W-1:0] r);
      return AW'(int'(c) * GRID_SIDE + int'(r));
   endfunction

   assign nb_side = mwmt_pkg::neighbor(col_ff, row_ff, cmd.side, SIDE);
   assign nb_dir = mwmt_pkg::neighbor(col_ff, row_ff, req_ff.direction, SIDE);
   assign cur_addr = cell_addr(col_ff, row_ff);
   assign side_addr = cell_addr(nb_side.col, nb_side.row);
   assign dir_addr = cell_addr(nb_dir.col, nb_dir.row);
   assign query_in_map = ({1'b0, req_ff.query_x} < SIDE) && ({1'b0, req_ff.query_y} < SIDE);
   assign query_addr = query_in_map ? cell_addr(req_ff.query_x, req_ff.query_y) : '0;

   assign status.command = mwmt_pkg::cmd_type'(req_ff.command);
   assign status.nb_in_map = nb_side.in_map;

   assign h_right = heading_ff + 2'd1;
   assign h_rear = heading_ff + 2'd2;
   assign h_left = heading_ff + 2'd3;
   assign opp_side = cmd.side + 2'd2;

   always_comb begin
      abs_wall = '0;
      abs_wall[heading_ff] = req_ff.wall_front;
      abs_wall[h_right] = req_ff.wall_right;
      abs_wall[h_rear] = req_ff.wall_rear;
      abs_wall[h_left] = req_ff.wall_left;
   end

   assign cell_rd = rd_valid_ff ? mwmt_pkg::cell_type'(ram_rd) : '0;

   always_comb begin
      cur_wr.visited = 1'b1;
      cur_wr.known = 4'hF;
      cur_wr.wall = abs_wall;
      nb_wr_data = cell_rd;
      nb_wr_data.known[opp_side] = 1'b1;
      nb_wr_data.wall[opp_side] = abs_wall[cmd.side];
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = cur_addr;
      wr_data = cur_wr;
      if (cmd.exec && (status.command == mwmt_pkg::CMD_RECORD)) begin
         wr_en = 1'b1;
      end else if (cmd.nb_wr) begin
         wr_en = 1'b1;
         wr_addr = side_addr;
         wr_data = nb_wr_data;
      end
   end

   always_comb begin
      rd_en = 1'b1;
      rd_addr = query_addr;
      priority if (cmd.exec && (status.command == mwmt_pkg::CMD_QUERY)) begin
         rd_addr = cur_addr;
      end else if (cmd.nb_rd) begin
         rd_addr = side_addr;
      end else if (cmd.qcur) begin
         rd_addr = nb_dir.in_map ? dir_addr : cur_addr;
      end else if (cmd.qnb || cmd.cell_rd) begin
         rd_addr = query_addr;
      end else begin
         rd_en = 1'b0;
      end
   end

   mwmt_ram #(
      .WIDTH(mwmt_pkg::CELL_W),
      .DEPTH(CELLS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= HOME;
         row_ff <= HOME;
         heading_ff <= mwmt_pkg::DIR_NORTH;
         valid_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.resp;
         if (cmd.exec) begin
            unique case (status.command)
               mwmt_pkg::CMD_RESET: begin
                  col_ff <= HOME;
                  row_ff <= HOME;
                  heading_ff <= mwmt_pkg::DIR_NORTH;
                  valid_ff <= '0;
               end
               mwmt_pkg::CMD_MOVE: begin
                  heading_ff <= req_ff.direction;
                  if (nb_dir.in_map) begin
                     col_ff <= nb_dir.col;
                     row_ff <= nb_dir.row;
                  end
               end
               default: begin
               end
            endcase
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff <= req_item;
         turns_ff <= '0;
         open_ff <= 1'b0;
      end
      if (cmd.exec && (status.command == mwmt_pkg::CMD_MOVE)) begin
         turns_ff <= req_ff.direction - heading_ff;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.qcur) begin
         cond_ff <= cell_rd.known[req_ff.direction] && !cell_rd.wall[req_ff.direction]
                    && nb_dir.in_map;
      end
      if (cmd.qnb) begin
         open_ff <= cond_ff && !cell_rd.visited;
      end
      if (cmd.resp) begin
         rsp_ff.pos_x <= col_ff;
         rsp_ff.pos_y <= row_ff;
         rsp_ff.heading_now <= heading_ff;
         rsp_ff.turns_needed <= turns_ff;
         rsp_ff.open_unvisited <= open_ff;
         rsp_ff.cell_visited <= query_in_map && cell_rd.visited;
         rsp_ff.cell_known_mask <= query_in_map ? cell_rd.known : '0;
         rsp_ff.cell_wall_mask <= query_in_map ? cell_rd.wall : '0;
         rsp_ff.cell_wall_count <= query_in_map ?
            3'($countones(cell_rd.known & cell_rd.wall)) : '0;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_pos_in_map: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < SIDE) && ({1'b0, row_ff} < SIDE))
      else $error("robot position left the map");

endmodule

// ===== rtl/core/maze_wall_map_tracker.sv =====
// A transaction is accepted on a rising edge with start high and busy low; its
// result appears on rsp_item for exactly one cycle with rsp_strobe high and must
// be taken then, as the receiver cannot hold it off. The cell map lives in a RAM
// with one read port, one write port and a registered read, one cell read a
// cycle. Reset map and move pass through execute, cell read and response; query
// through execute, current-cell query, neighbour query and response; record
// walls through execute, a neighbour read and write per neighbouring cell in the
// map, cell read and response. Busy falls in the cycle the result is shown, so a
// new transaction may be accepted alongside it. The map clears at once on reset
// or reset map through per-cell valid flags, so there is no clearing pass.
module maze_wall_map_tracker #(
   parameter int GRID_SIDE = mwmt_pkg::GRID_SIDE_DEFAULT,
   parameter int START_POS = mwmt_pkg::START_POS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mwmt_pkg::req_type req_item,
   output logic              rsp_strobe,
   output mwmt_pkg::rsp_type rsp_item
);

   mwmt_pkg::ctrl_cmd_type  cmd;
   mwmt_pkg::dp_status_type status;

   mwmt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .status(status),
      .cmd   (cmd)
   );

   mwmt_datapath #(
      .GRID_SIDE(GRID_SIDE),
      .START_POS(START_POS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

endmodule

// ===== bench/maze_wall_map_tracker_tb.sv =====
module maze_wall_map_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_SIDE = mwmt_pkg::GRID_SIDE_DEFAULT;
   localparam int START_POS = mwmt_pkg::START_POS_DEFAULT;
   localparam int HOME_POS = (START_POS < GRID_SIDE) ? START_POS : GRID_SIDE - 1;
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 16;

   class maze_map_checker;
      bit                visited[CELLS];
      logic [3:0]        known[CELLS];
      logic [3:0]        walls[CELLS];
      logic [3:0]        col;
      logic [3:0]        row;
      logic [1:0]        heading;
      mwmt_pkg::rsp_type expected_reports[$];
      int                failures;
      int                checked;
      int                open_hits;
      int                seen_cmd[4];

      function new();
         failures = 0;
         checked = 0;
         open_hits = 0;
         foreach (seen_cmd[i]) seen_cmd[i] = 0;
         clear_map();
      endfunction

      function void clear_map();
         foreach (visited[i]) begin
            visited[i] = 1'b0;
            known[i] = 4'd0;
            walls[i] = 4'd0;
         end
         col = 4'(HOME_POS);
         row = 4'(HOME_POS);
         heading = mwmt_pkg::DIR_NORTH;
      endfunction

      function int cell_at(logic [3:0] c, logic [3:0] r);
         return int'(c) * GRID_SIDE + int'(r);
      endfunction

      function bit step_toward(input logic [3:0] c, input logic [3:0] r,
                               input logic [1:0] d,
                               output logic [3:0] nc, output logic [3:0] nr);
         nc = c;
         nr = r;
         case (d)
            mwmt_pkg::DIR_NORTH: begin
               if (int'(r) + 1 >= GRID_SIDE) return 1'b0;
               nr = r + 4'd1;
            end
            mwmt_pkg::DIR_EAST: begin
               if (int'(c) + 1 >= GRID_SIDE) return 1'b0;
               nc = c + 4'd1;
            end
            mwmt_pkg::DIR_SOUTH: begin
               if (r == 4'd0) return 1'b0;
               nr = r - 4'd1;
            end
            default: begin
               if (c == 4'd0) return 1'b0;
               nc = c - 4'd1;
            end
         endcase
         return 1'b1;
      endfunction

      function void write_side(int idx, logic [1:0] d, logic wall);
         known[idx][d] = 1'b1;
         walls[idx][d] = wall;
      endfunction

      function void mark_side(logic [1:0] d, logic wall);
         logic [3:0] nc;
         logic [3:0] nr;
         write_side(cell_at(col, row), d, wall);
         if (step_toward(col, row, d, nc, nr)) write_side(cell_at(nc, nr), d + 2'd2, wall);
      endfunction

      function mwmt_pkg::rsp_type predict_report(mwmt_pkg::req_type r);
         mwmt_pkg::rsp_type o;
         logic [3:0]        nc;
         logic [3:0]        nr;
         logic [1:0]        h;
         int                idx;
         o = '0;
         case (mwmt_pkg::cmd_type'(r.command))
            mwmt_pkg::CMD_RESET: clear_map();
            mwmt_pkg::CMD_RECORD: begin
               h = heading;
               mark_side(h, r.wall_front);
               mark_side(h + 2'd3, r.wall_left);
               mark_side(h + 2'd1, r.wall_right);
               mark_side(h + 2'd2, r.wall_rear);
               visited[cell_at(col, row)] = 1'b1;
            end
            mwmt_pkg::CMD_MOVE: begin
               o.turns_needed = r.direction - heading;
               heading = r.direction;
               if (step_toward(col, row, r.direction, nc, nr)) begin
                  col = nc;
                  row = nr;
               end
            end
            default: begin
               idx = cell_at(col, row);
               if (known[idx][r.direction] && !walls[idx][r.direction] &&
                   step_toward(col, row, r.direction, nc, nr))
                  o.open_unvisited = !visited[cell_at(nc, nr)];
            end
         endcase
         if (int'(r.query_x) < GRID_SIDE && int'(r.query_y) < GRID_SIDE) begin
            idx = cell_at(r.query_x, r.query_y);
            o.cell_visited = visited[idx];
            o.cell_known_mask = known[idx];
            o.cell_wall_mask = walls[idx];
            o.cell_wall_count = 3'($countones(known[idx] & walls[idx]));
         end
         o.pos_x = col;
         o.pos_y = row;
         o.heading_now = heading;
         return o;
      endfunction

      function void note_command(mwmt_pkg::req_type r);
         mwmt_pkg::rsp_type o;
         o = predict_report(r);
         seen_cmd[r.command]++;
         if (o.open_unvisited) open_hits++;
         expected_reports.push_back(o);
      endfunction

      function string show(mwmt_pkg::rsp_type o);
         return $sformatf("pos %0d,%0d hdg %0d turns %0d open %b vis %b known %b wall %b cnt %0d",
                          o.pos_x, o.pos_y, o.heading_now, o.turns_needed, o.open_unvisited,
                          o.cell_visited, o.cell_known_mask, o.cell_wall_mask,
                          o.cell_wall_count);
      endfunction

      function void check_result(mwmt_pkg::rsp_type got);
         mwmt_pkg::rsp_type exp;
         if (expected_reports.size() == 0) begin
            failures++;
            if (failures <= 10) $display("Unexpected result: %s", show(got));
            return;
         end
         exp = expected_reports.pop_front();
         checked++;
         if (got.pos_x !== exp.pos_x || got.pos_y !== exp.pos_y ||
             got.heading_now !== exp.heading_now || got.turns_needed !== exp.turns_needed ||
             got.open_unvisited !== exp.open_unvisited ||
             got.cell_visited !== exp.cell_visited ||
             got.cell_known_mask !== exp.cell_known_mask ||
             got.cell_wall_mask !== exp.cell_wall_mask ||
             got.cell_wall_count !== exp.cell_wall_count) begin
            failures++;
            if (failures <= 10) begin
               $display("Mismatch on result %0d", checked);
               $display("  expected %s", show(exp));
               $display("  actual   %s", show(got));
            end
         end
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   mwmt_pkg::req_type req_item = '0;
   logic              busy;
   logic              rsp_strobe;
   mwmt_pkg::rsp_type rsp_item;

   maze_map_checker tracker;
   int              idle_pct = 0;
   int              cycle_count = 0;

   maze_wall_map_tracker #(
      .GRID_SIDE(GRID_SIDE),
      .START_POS(START_POS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, tracker.pending());
         $display("maze_wall_map_tracker verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe !== 1'b0) tracker.check_result(rsp_item);
         if (start && busy === 1'b0) tracker.note_command(req_item);
      end
   end

   function automatic mwmt_pkg::req_type make_request(mwmt_pkg::cmd_type c,
                                                      logic [3:0] sensed, logic [1:0] d,
                                                      int qx, int qy);
      mwmt_pkg::req_type r;
      r.command = c;
      {r.wall_front, r.wall_left, r.wall_right, r.wall_rear} = sensed;
      r.direction = d;
      r.query_x = 4'(qx);
      r.query_y = 4'(qy);
      return r;
   endfunction

   function automatic mwmt_pkg::req_type random_request(mwmt_pkg::cmd_type c);
      int qx;
      int qy;
      if ($urandom_range(99) < 85) begin
         qx = $urandom_range(GRID_SIDE - 1);
         qy = $urandom_range(GRID_SIDE - 1);
      end else begin
         qx = $urandom_range(15);
         qy = $urandom_range(15);
      end
      return make_request(c, 4'($urandom_range(15)), 2'($urandom_range(3)), qx, qy);
   endfunction

   task automatic send_command(mwmt_pkg::req_type r);
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   initial begin
      int                n;
      int                k;
      int                pick;
      mwmt_pkg::req_type r;
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(make_request(mwmt_pkg::CMD_RESET, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_RECORD, 4'b0101, mwmt_pkg::DIR_NORTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_EAST, 5, 4));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_WEST, 3, 4));
      send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 5));
      send_command(make_request(mwmt_pkg::CMD_RECORD, 4'b1110, mwmt_pkg::DIR_NORTH, 4, 5));
      send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b0000, mwmt_pkg::DIR_SOUTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b0000, mwmt_pkg::DIR_EAST, 5, 4));
      send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b0000, mwmt_pkg::DIR_WEST, 4, 4));
      send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 5));
      repeat (4) begin
         send_command(make_request(mwmt_pkg::CMD_MOVE, 4'b1111, mwmt_pkg::DIR_NORTH, 4, 8));
      end
      send_command(make_request(mwmt_pkg::CMD_RECORD, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 8));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 8));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_SOUTH, 4, 7));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b1111, mwmt_pkg::DIR_WEST, 15, 15));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_EAST, 9, 0));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_EAST, 0, 8));
      send_command(make_request(mwmt_pkg::CMD_RESET, 4'b1111, mwmt_pkg::DIR_WEST, 4, 8));
      send_command(make_request(mwmt_pkg::CMD_QUERY, 4'b0000, mwmt_pkg::DIR_NORTH, 4, 4));

      n = 0;
      while (n < RANDOM_ITEMS) begin
         idle_pct = (n < RANDOM_ITEMS / 3) ? 38 : (n < 2 * RANDOM_ITEMS / 3) ? 52 : 0;
         pick = $urandom_range(99);
         if (pick < 3) begin
            send_command(random_request(mwmt_pkg::CMD_RESET));
            n++;
         end else if (pick < 75) begin
            k = $urandom_range(1, 2);
            send_command(random_request(mwmt_pkg::CMD_RECORD));
            repeat (k) send_command(random_request(mwmt_pkg::CMD_QUERY));
            send_command(random_request(mwmt_pkg::CMD_MOVE));
            n += 2 + k;
         end else begin
            r = 16'($urandom);
            send_command(r);
            n++;
         end
      end
      start <= 1'b0;

      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d reset, %0d record, %0d move and %0d query transactions.",
               tracker.seen_cmd[mwmt_pkg::CMD_RESET], tracker.seen_cmd[mwmt_pkg::CMD_RECORD],
               tracker.seen_cmd[mwmt_pkg::CMD_MOVE], tracker.seen_cmd[mwmt_pkg::CMD_QUERY]);
      $display("Checked %0d results, %0d with an open unvisited neighbour, %0d failures.",
               tracker.checked, tracker.open_hits, tracker.failures);
      if (tracker.failures == 0) begin
         $display("maze_wall_map_tracker verification clean");
      end else begin
         $display("maze_wall_map_tracker verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/mwmt_pkg.sv
rtl/core/mwmt_ram.sv
rtl/core/mwmt_ctrl.sv
rtl/core/mwmt_datapath.sv
rtl/core/maze_wall_map_tracker.sv
bench/maze_wall_map_tracker_tb.sv
